// ===== src/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the binary max-heap queue
// Sizes, status and action codes, and the memory request/response structs.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Child indexes 2*pos+1 and 2*pos+2 need two more bits than an address.
	localparam int CHILD_W  = ADDR_W + 2;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata_a;
		logic [DATA_W-1:0] rdata_b;
	} mem_rsp_t;

endpackage

// ===== src/binary_max_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit: max-priority queue on a binary heap
// Sequencer plus entry memory; one command in flight at a time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low: action 0 inserts the
// signed value, action 1 removes the largest entry. Each transaction ends with
// exactly one result, shown for a single cycle with done high; the receiver
// cannot stall it, so it must capture the result in that cycle. Refused
// commands (insert into a full heap, remove from an empty one) answer in the
// cycle after they are taken with status 1 or 2 and leave the heap untouched.
// An insert sifts up one level at a time, each level passing through a read
// state and a compare-and-write state, and ends when the value reaches the
// root or a parent stops it. A remove first reads the root and the last entry,
// then sifts down the same way and ends when the moved entry runs out of
// children or a child stops it. The entry memory sets this pace: each heap
// level needs its own read state because the memory returns registered read
// data, so the compare waits for the data read in the state before it.
// busy drops in the done cycle, so the next command may be taken there.
module binary_max_heap_queue_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               action,
	input  logic signed [bmhq_pkg::DATA_W-1:0] value,
	output logic                               busy,
	output logic                               done,
	output logic signed [bmhq_pkg::DATA_W-1:0] removed_value,
	output logic [bmhq_pkg::STATUS_W-1:0]      status,
	output logic [bmhq_pkg::COUNT_W-1:0]       entry_count
);

	// Requests from the sequencer and registered read data back from memory.
	// Reads and writes never target the same cycle in the sequencer, so the
	// state order alone keeps a read from seeing a stale entry.
	bmhq_pkg::mem_req_t mem_req;
	bmhq_pkg::mem_rsp_t mem_rsp;

	bmhq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.action        (action),
		.value         (value),
		.busy          (busy),
		.done          (done),
		.removed_value (removed_value),
		.status        (status),
		.entry_count   (entry_count),
		.mem_req       (mem_req),
		.mem_rsp       (mem_rsp)
	);

	bmhq_mem u_mem (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

`ifndef SYNTHESIS
	// The result cycle always finds the sequencer idle again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done asserted while busy");

	// A taken command is either still working or answering in the next cycle.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction vanished");

	// A refused insert can only come from a full heap.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == bmhq_pkg::STATUS_FULL)) |->
		(entry_count == bmhq_pkg::COUNT_W'(bmhq_pkg::CAPACITY)))
		else $error("full refusal with wrong count");

	// A refused remove reports an empty heap and a zero value.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == bmhq_pkg::STATUS_EMPTY)) |->
		((entry_count == '0) && (removed_value == '0)))
		else $error("empty refusal with wrong result");
`endif

endmodule

// ===== src/bmhq_mem.sv =====
// ----------------------------------------------------------------------------
// bmhq_mem: heap entry storage
// One write port and two registered read ports; reads return old data.
// ----------------------------------------------------------------------------
module bmhq_mem (
	input  logic               clk,
	input  bmhq_pkg::mem_req_t req,
	output bmhq_pkg::mem_rsp_t rsp
);

	logic [bmhq_pkg::DATA_W-1:0] mem_q [bmhq_pkg::CAPACITY];
	logic [bmhq_pkg::DATA_W-1:0] rdata_a_q;
	logic [bmhq_pkg::DATA_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_a_q <= mem_q[req.raddr_a];
		rdata_b_q <= mem_q[req.raddr_b];
	end

	assign rsp.rdata_a = rdata_a_q;
	assign rsp.rdata_b = rdata_b_q;

endmodule

// ===== src/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl: heap sequencer
// Runs sift-up for inserts and sift-down for removes against the entry
// memory, keeps the fill count and registers the result of each transaction.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                action,
	input  logic signed [bmhq_pkg::DATA_W-1:0]  value,
	output logic                                busy,
	output logic                                done,
	output logic signed [bmhq_pkg::DATA_W-1:0]  removed_value,
	output logic [bmhq_pkg::STATUS_W-1:0]       status,
	output logic [bmhq_pkg::COUNT_W-1:0]        entry_count,
	output bmhq_pkg::mem_req_t                  mem_req,
	input  bmhq_pkg::mem_rsp_t                  mem_rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_URD  = 3'd1;
	localparam logic [2:0] ST_UCMP = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;
	localparam logic [2:0] ST_DRD  = 3'd5;
	localparam logic [2:0] ST_DCMP = 3'd6;

	logic [2:0]                    state_q, state_d;
	logic [bmhq_pkg::CNT_W-1:0]    count_q;
	logic                          done_q;
	logic [bmhq_pkg::ADDR_W-1:0]   pos_q;
	logic [bmhq_pkg::ADDR_W-1:0]   up_q;
	logic [bmhq_pkg::DATA_W-1:0]   hold_q;
	logic [bmhq_pkg::DATA_W-1:0]   top_q;
	logic [bmhq_pkg::DATA_W-1:0]   removed_q;
	logic [bmhq_pkg::STATUS_W-1:0] status_q;

	logic                          accept;
	logic                          is_full;
	logic                          is_empty;
	logic                          refuse;
	logic                          finish;
	logic [bmhq_pkg::ADDR_W-1:0]   parent;
	logic [bmhq_pkg::CHILD_W-1:0]  left_c;
	logic [bmhq_pkg::CHILD_W-1:0]  right_c;
	logic [bmhq_pkg::CHILD_W-1:0]  n_c;
	logic                          left_ok;
	logic                          right_ok;
	logic                          pick_left;
	logic [bmhq_pkg::DATA_W-1:0]   pick_val;
	logic [bmhq_pkg::ADDR_W-1:0]   pick_idx;
	logic                          up_move;
	logic                          down_move;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign is_full  = (count_q >= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
	assign is_empty = (count_q == '0);
	assign refuse   = accept && (((action == bmhq_pkg::ACT_INSERT) && is_full) ||
	                             ((action == bmhq_pkg::ACT_REMOVE) && is_empty));

	assign parent   = (pos_q - bmhq_pkg::ADDR_W'(1)) >> 1;
	assign left_c   = bmhq_pkg::CHILD_W'({pos_q, 1'b1});
	assign right_c  = left_c + bmhq_pkg::CHILD_W'(1);
	assign n_c      = bmhq_pkg::CHILD_W'(count_q);
	assign left_ok  = (left_c < n_c);
	assign right_ok = (right_c < n_c);

	// The left child wins when strictly greater than the right one, or when there is no right child.
	assign pick_left = !right_ok ||
	                   ($signed(mem_rsp.rdata_a) > $signed(mem_rsp.rdata_b));
	assign pick_val  = pick_left ? mem_rsp.rdata_a : mem_rsp.rdata_b;
	assign pick_idx  = pick_left ? left_c[bmhq_pkg::ADDR_W-1:0]
	                             : right_c[bmhq_pkg::ADDR_W-1:0];

	assign up_move   = ($signed(hold_q) > $signed(mem_rsp.rdata_a));
	assign down_move = ($signed(hold_q) < $signed(pick_val));

	always_comb begin
		mem_req         = '0;
		mem_req.waddr   = pos_q;
		mem_req.wdata   = hold_q;
		finish          = 1'b0;
		state_d         = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !refuse) begin
					state_d = (action == bmhq_pkg::ACT_INSERT) ? ST_URD : ST_ROOT;
				end
			end
			ST_URD: begin
				if (pos_q == '0) begin
					mem_req.we = 1'b1;
					finish     = 1'b1;
				end else begin
					mem_req.raddr_a = parent;
					state_d         = ST_UCMP;
				end
			end
			ST_UCMP: begin
				mem_req.we = 1'b1;
				if (up_move) begin
					mem_req.wdata = mem_rsp.rdata_a;
					state_d       = ST_URD;
				end else begin
					finish = 1'b1;
				end
			end
			ST_ROOT: begin
				// The count has already dropped, so it indexes the last entry.
				mem_req.raddr_a = '0;
				mem_req.raddr_b = count_q[bmhq_pkg::ADDR_W-1:0];
				state_d         = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_DRD;
			end
			ST_DRD: begin
				if (!left_ok) begin
					mem_req.we = 1'b1;
					finish     = 1'b1;
				end else begin
					mem_req.raddr_a = left_c[bmhq_pkg::ADDR_W-1:0];
					mem_req.raddr_b = right_c[bmhq_pkg::ADDR_W-1:0];
					state_d         = ST_DCMP;
				end
			end
			ST_DCMP: begin
				mem_req.we = 1'b1;
				if (down_move) begin
					mem_req.wdata = pick_val;
					state_d       = ST_DRD;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (finish) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish || refuse;
			if (accept && !refuse) begin
				if (action == bmhq_pkg::ACT_INSERT) begin
					count_q <= count_q + bmhq_pkg::CNT_W'(1);
				end else begin
					count_q <= count_q - bmhq_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q    <= value;
			pos_q     <= count_q[bmhq_pkg::ADDR_W-1:0];
			removed_q <= '0;
			if (action == bmhq_pkg::ACT_INSERT) begin
				status_q <= is_full ? bmhq_pkg::STATUS_FULL : bmhq_pkg::STATUS_DONE;
			end else begin
				status_q <= is_empty ? bmhq_pkg::STATUS_EMPTY : bmhq_pkg::STATUS_DONE;
			end
		end
		case (state_q)
			ST_URD: begin
				up_q <= parent;
			end
			ST_UCMP: begin
				if (up_move) begin
					pos_q <= up_q;
				end
			end
			ST_LOAD: begin
				top_q  <= mem_rsp.rdata_a;
				hold_q <= mem_rsp.rdata_b;
				pos_q  <= '0;
			end
			ST_DRD: begin
				if (!left_ok) begin
					removed_q <= top_q;
				end
			end
			ST_DCMP: begin
				if (down_move) begin
					pos_q <= pick_idx;
				end else begin
					removed_q <= top_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done          = done_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = bmhq_pkg::COUNT_W'(count_q);

endmodule
